[hw/rtl/e2q_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants, cell payload types and helper functions for the
// euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // port widths
  localparam int ANGLE_BITS = 16;
  localparam int OUT_BITS   = 16;

  // cordic datapath
  localparam int STEPS  = 30;
  localparam int STEP_W = $clog2(STEPS);
  localparam int DW     = 32;
  localparam int ZW     = 34;
  localparam int LANES  = 3;
  localparam int ASHIFT = 32 - ANGLE_BITS;

  // lane numbers
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // q30 constants
  localparam logic signed [DW-1:0] GAIN_INV_Q30 = 32'sd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;

  // product and output widths
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int FRAC = OUT_BITS - 2;
  localparam int RSH  = 60 - FRAC;

  localparam logic signed [SW-1:0]       RND_Q60 = SW'(1) <<< (59 - FRAC);
  localparam logic signed [OUT_BITS-1:0] ONE_Q   = OUT_BITS'(1) <<< FRAC;
  localparam logic signed [SW-1:0]       ONE_W   = SW'(1) <<< FRAC;

  // one rotation lane
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } lane_t;

  // payload handed from cell to cell
  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic  [LANES-1:0] neg;
  } cell_t;

  // truncated arctangent table, q30
  function automatic logic signed [DW-1:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic signed [DW-1:0] v;
    case (idx)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      5'd24:   v = 32'sh0000003F;
      5'd25:   v = 32'sh0000001F;
      5'd26:   v = 32'sh0000000F;
      5'd27:   v = 32'sh00000008;
      5'd28:   v = 32'sh00000004;
      5'd29:   v = 32'sh00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up from q60, then clamp to plus or minus one
  function automatic logic signed [OUT_BITS-1:0] finish_q(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    logic signed [OUT_BITS-1:0] o;
    r = (s + RND_Q60) >>> RSH;
    if (r > ONE_W) begin
      o = ONE_Q;
    end else if (r < -ONE_W) begin
      o = -ONE_Q;
    end else begin
      o = OUT_BITS'(r);
    end
    return o;
  endfunction

endpackage

[hw/rtl/e2q_fold_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_fold_cell
// Head cell of the chain: halves the three angles into q30, folds them into
// plus or minus pi/2 and seeds the rotation lanes.
// ----------------------------------------------------------------------------
module e2q_fold_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] roll_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] pitch_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] yaw_angle_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output e2q_pkg::cell_t                        data_o
);

  logic           valid_q;
  e2q_pkg::cell_t data_d, data_q;
  logic           load;

  // half angle, quadrant fold and lane seed
  always_comb begin
    logic signed [e2q_pkg::ANGLE_BITS-1:0] ang [e2q_pkg::LANES];
    logic signed [e2q_pkg::ZW-1:0]         zw;
    ang[e2q_pkg::LANE_ROLL]  = roll_angle_i;
    ang[e2q_pkg::LANE_PITCH] = pitch_angle_i;
    ang[e2q_pkg::LANE_YAW]   = yaw_angle_i;
    data_d = '0;
    for (int l = 0; l < e2q_pkg::LANES; l++) begin
      zw = e2q_pkg::ZW'(ang[l]) <<< e2q_pkg::ASHIFT;
      data_d.neg[l] = 1'b0;
      if (zw > e2q_pkg::HALF_PI_Q30) begin
        zw = zw - e2q_pkg::PI_Q30;
        data_d.neg[l] = 1'b1;
      end else if (zw < -e2q_pkg::HALF_PI_Q30) begin
        zw = zw + e2q_pkg::PI_Q30;
        data_d.neg[l] = 1'b1;
      end
      data_d.lane[l].x = e2q_pkg::GAIN_INV_Q30;
      data_d.lane[l].y = '0;
      data_d.lane[l].z = zw[e2q_pkg::DW-1:0];
    end
  end

  // handshake: take a new item when empty or when the next cell takes ours
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/e2q_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One rotation step for the three angle lanes; the step number is tied to a
// constant by the parent, so shifts and the arctangent entry fold away.
// ----------------------------------------------------------------------------
module e2q_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [e2q_pkg::STEP_W-1:0]   step_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  e2q_pkg::cell_t               data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output e2q_pkg::cell_t               data_o
);

  logic           valid_q;
  e2q_pkg::cell_t data_d, data_q;
  logic           load;

  // rotate each lane toward z = 0
  always_comb begin
    logic signed [e2q_pkg::DW-1:0] x, y, z, xs, ys, at;
    data_d = data_i;
    at = e2q_pkg::atan_q30(step_i);
    for (int l = 0; l < e2q_pkg::LANES; l++) begin
      x  = data_i.lane[l].x;
      y  = data_i.lane[l].y;
      z  = data_i.lane[l].z;
      xs = x >>> step_i;
      ys = y >>> step_i;
      if (!z[e2q_pkg::DW-1]) begin
        data_d.lane[l].x = x - ys;
        data_d.lane[l].y = y + xs;
        data_d.lane[l].z = z - at;
      end else begin
        data_d.lane[l].x = x + ys;
        data_d.lane[l].y = y - xs;
        data_d.lane[l].z = z + at;
      end
    end
  end

  // handshake
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/e2q_quat_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_quat_unit
// Tail of the chain: sign fix and pair products, triple products, then sums,
// rounding and clamping into the output register.
// ----------------------------------------------------------------------------
module e2q_quat_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  e2q_pkg::cell_t                      data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_w_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_x_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_y_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_z_o
);

  localparam int DW = e2q_pkg::DW;
  localparam int PW = e2q_pkg::PW;
  localparam int SW = e2q_pkg::SW;

  // pair product slots
  localparam int P_CC = 0;  // cy * cp
  localparam int P_SS = 1;  // sy * sp
  localparam int P_SC = 2;  // sy * cp
  localparam int P_CS = 3;  // cy * sp

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // stage one: cosine and sine with sign restored, pair products
  logic signed [DW-1:0] c [e2q_pkg::LANES];
  logic signed [DW-1:0] s [e2q_pkg::LANES];
  logic signed [PW-1:0] pm [4];
  logic signed [DW-1:0] pair_q [4];
  logic signed [DW-1:0] cr_q, sr_q;

  always_comb begin
    for (int l = 0; l < e2q_pkg::LANES; l++) begin
      c[l] = data_i.neg[l] ? -data_i.lane[l].x : data_i.lane[l].x;
      s[l] = data_i.neg[l] ? -data_i.lane[l].y : data_i.lane[l].y;
    end
  end

  assign pm[P_CC] = c[e2q_pkg::LANE_YAW] * c[e2q_pkg::LANE_PITCH];
  assign pm[P_SS] = s[e2q_pkg::LANE_YAW] * s[e2q_pkg::LANE_PITCH];
  assign pm[P_SC] = s[e2q_pkg::LANE_YAW] * c[e2q_pkg::LANE_PITCH];
  assign pm[P_CS] = c[e2q_pkg::LANE_YAW] * s[e2q_pkg::LANE_PITCH];

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      for (int k = 0; k < 4; k++) begin
        pair_q[k] <= pm[k][DW+29:30];
      end
      cr_q <= c[e2q_pkg::LANE_ROLL];
      sr_q <= s[e2q_pkg::LANE_ROLL];
    end
  end

  // stage two: triple products, q60
  logic signed [PW-1:0] t_q [8];

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      t_q[0] <= pair_q[P_CC] * cr_q;
      t_q[1] <= pair_q[P_SS] * sr_q;
      t_q[2] <= pair_q[P_CC] * sr_q;
      t_q[3] <= pair_q[P_SS] * cr_q;
      t_q[4] <= pair_q[P_SC] * sr_q;
      t_q[5] <= pair_q[P_CS] * cr_q;
      t_q[6] <= pair_q[P_SC] * cr_q;
      t_q[7] <= pair_q[P_CS] * sr_q;
    end
  end

  // stage three: sums, rounding and clamping into the output register
  logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z;
  logic signed [e2q_pkg::OUT_BITS-1:0] qw_q, qx_q, qy_q, qz_q;

  assign sum_w = SW'(t_q[0]) + SW'(t_q[1]);
  assign sum_x = SW'(t_q[2]) - SW'(t_q[3]);
  assign sum_y = SW'(t_q[4]) + SW'(t_q[5]);
  assign sum_z = SW'(t_q[6]) - SW'(t_q[7]);

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      qw_q <= e2q_pkg::finish_q(sum_w);
      qx_q <= e2q_pkg::finish_q(sum_x);
      qy_q <= e2q_pkg::finish_q(sum_y);
      qz_q <= e2q_pkg::finish_q(sum_z);
    end
  end

  // stage handshake, bubbles collapse toward the output
  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign valid_o  = v3_q;
  assign quat_w_o = qw_q;
  assign quat_x_o = qx_q;
  assign quat_y_o = qy_q;
  assign quat_z_o = qz_q;

endmodule

[hw/rtl/euler_to_quaternion.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw in q3.13 radians to a z-y-x unit quaternion in q1.14.
// ----------------------------------------------------------------------------
// The block takes one angle triple per clock while input ready is high and
// returns one quaternion per item, in order. Each item passes the half-angle
// fold register, one cordic cell per rotation step in a row of 30, the pair
// products, the triple products and rounding into the output register.
// Every stage has its own valid bit, so a stalled output only holds back
// input once all 34 stages are full; with the output always taken, input
// ready stays high.
module euler_to_quaternion (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] roll_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] pitch_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] yaw_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_w_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_x_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_y_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0] quat_z_o
);

  localparam int N = e2q_pkg::STEPS;

  // links between cells; link 0 leaves the fold cell
  e2q_pkg::cell_t link_data  [N+1];
  logic           link_valid [N+1];
  logic           link_ready [N+1];

  // head cell
  e2q_fold_cell u_fold (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .roll_angle_i  (roll_angle_i),
    .pitch_angle_i (pitch_angle_i),
    .yaw_angle_i   (yaw_angle_i),
    .valid_o       (link_valid[0]),
    .ready_i       (link_ready[0]),
    .data_o        (link_data[0])
  );

  // row of rotation cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (e2q_pkg::STEP_W'(g)),
      .valid_i (link_valid[g]),
      .ready_o (link_ready[g]),
      .data_i  (link_data[g]),
      .valid_o (link_valid[g+1]),
      .ready_i (link_ready[g+1]),
      .data_o  (link_data[g+1])
    );
  end

  // products and output register
  e2q_quat_unit u_quat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (link_valid[N]),
    .ready_o  (link_ready[N]),
    .data_i   (link_data[N]),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the euler angle to quaternion pipeline against a bit-exact model of
// its cordic half-angle sine and cosine, triple products and q1.14 rounding.
// Directed corner triples come first. A drain pause, a backpressure burst and
// a long random stream follow; the burst sends back to back, the others
// may add random gaps on both handshakes. Every result is compared field by
// field with the oldest predicted quaternion.
module tb_top;

  // widths from the design package
  localparam int ANGLE_BITS = e2q_pkg::ANGLE_BITS;
  localparam int OUT_BITS   = e2q_pkg::OUT_BITS;

  // cordic constants in q30
  localparam int     ROT_STEPS   = 30;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam int     OUT_FRAC    = OUT_BITS - 2;

  // pi in q3.13 sits at the half-angle fold boundary
  localparam logic signed [ANGLE_BITS-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANGLE_BITS-1:0] ANG_HALF_PI = 16'sd12868;
  localparam logic signed [ANGLE_BITS-1:0] ANG_MAX     = 16'sh7fff;
  localparam logic signed [ANGLE_BITS-1:0] ANG_MIN     = 16'sh8000;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CHUNK_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] w;
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
  } quat_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_ready_o;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic                         out_valid_o;
  logic                         out_ready;
  logic signed [OUT_BITS-1:0]   quat_w_o;
  logic signed [OUT_BITS-1:0]   quat_x_o;
  logic signed [OUT_BITS-1:0]   quat_y_o;
  logic signed [OUT_BITS-1:0]   quat_z_o;

  quat_t quat_expected[$];
  int    fail_count;
  int    tx_max_gap;
  int    rx_max_stall;

  euler_to_quaternion dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .roll_angle_i (roll_angle),
    .pitch_angle_i(pitch_angle),
    .yaw_angle_i  (yaw_angle),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .quat_w_o     (quat_w_o),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o)
  );

  // clock, 20 ns period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // truncated arctangent of 2^-i in q30
  function automatic longint arctan_q30(input int i);
    longint v;
    case (i)
      0:       v = 64'h3243F6A8;
      1:       v = 64'h1DAC6705;
      2:       v = 64'h0FADBAFC;
      3:       v = 64'h07F56EA6;
      4:       v = 64'h03FEAB76;
      5:       v = 64'h01FFD55B;
      6:       v = 64'h00FFFAAA;
      7:       v = 64'h007FFF55;
      8:       v = 64'h003FFFEA;
      9:       v = 64'h001FFFFD;
      10:      v = 64'h000FFFFF;
      11:      v = 64'h0007FFFF;
      12:      v = 64'h0003FFFF;
      13:      v = 64'h0001FFFF;
      14:      v = 64'h0000FFFF;
      15:      v = 64'h00007FFF;
      16:      v = 64'h00003FFF;
      17:      v = 64'h00001FFF;
      18:      v = 64'h00000FFF;
      19:      v = 64'h000007FF;
      20:      v = 64'h000003FF;
      21:      v = 64'h000001FF;
      22:      v = 64'h000000FF;
      23:      v = 64'h0000007F;
      24:      v = 64'h0000003F;
      25:      v = 64'h0000001F;
      26:      v = 64'h0000000F;
      27:      v = 64'h00000008;
      28:      v = 64'h00000004;
      default: v = 64'h00000002;
    endcase
    return v;
  endfunction

  // cosine and sine of half the angle, q30, with quadrant fold
  function automatic void half_angle_sincos(input logic signed [ANGLE_BITS-1:0] ang,
                                            output longint cos_q30,
                                            output longint sin_q30);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    z    = longint'(ang) * (longint'(1) <<< (32 - ANGLE_BITS));
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z    = z - PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z    = z + PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_q30(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_q30(i);
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // pair product floored to q30, times the third factor, q60
  function automatic longint scaled_triple(input longint a, input longint b, input longint c);
    return ((a * b) >>> 30) * c;
  endfunction

  // round half up from q60 to q1.14, clamp to plus or minus one
  function automatic logic signed [OUT_BITS-1:0] round_saturate(input longint q60);
    longint r;
    longint one;
    one = longint'(1) <<< OUT_FRAC;
    r   = (q60 + (longint'(1) <<< (59 - OUT_FRAC))) >>> (60 - OUT_FRAC);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OUT_BITS-1:0];
  endfunction

  // z-y-x quaternion from roll, pitch and yaw
  function automatic quat_t predict_quaternion(input logic signed [ANGLE_BITS-1:0] roll,
                                               input logic signed [ANGLE_BITS-1:0] pitch,
                                               input logic signed [ANGLE_BITS-1:0] yaw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t  q;
    half_angle_sincos(roll, cr, sr);
    half_angle_sincos(pitch, cp, sp);
    half_angle_sincos(yaw, cy, sy);
    q.w = round_saturate(scaled_triple(cy, cp, cr) + scaled_triple(sy, sp, sr));
    q.x = round_saturate(scaled_triple(cy, cp, sr) - scaled_triple(sy, sp, cr));
    q.y = round_saturate(scaled_triple(sy, cp, sr) + scaled_triple(cy, sp, cr));
    q.z = round_saturate(scaled_triple(sy, cp, cr) - scaled_triple(cy, sp, sr));
    return q;
  endfunction

  // predict at every accepted input item
  always @(posedge clk_i) begin
    if (in_valid && in_ready_o) begin
      quat_expected.push_back(predict_quaternion(roll_angle, pitch_angle, yaw_angle));
    end
  end

  task automatic compare_field(input string name,
                               input logic signed [OUT_BITS-1:0] want,
                               input logic signed [OUT_BITS-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result sink: random stalls on ready, check each accepted item
  initial begin : result_sink
    int    stall;
    quat_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (quat_expected.size() == 0) begin
        $error("result item with no prediction waiting");
        fail_count++;
      end else begin
        want = quat_expected.pop_front();
        compare_field("quat_w", want.w, quat_w_o);
        compare_field("quat_x", want.x, quat_x_o);
        compare_field("quat_y", want.y, quat_y_o);
        compare_field("quat_z", want.z, quat_z_o);
      end
    end
  end

  // send one angle triple, with a random gap before it
  task automatic send_item(input logic signed [ANGLE_BITS-1:0] roll,
                           input logic signed [ANGLE_BITS-1:0] pitch,
                           input logic signed [ANGLE_BITS-1:0] yaw);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    roll_angle  <= roll;
    pitch_angle <= pitch;
    yaw_angle   <= yaw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // angle near a corner: extremes, zero, fold boundary, quarter turn
  function automatic logic signed [ANGLE_BITS-1:0] corner_angle();
    logic signed [ANGLE_BITS-1:0] a;
    logic signed [ANGLE_BITS-1:0] jitter;
    jitter = ANGLE_BITS'($urandom_range(0, 6)) - 16'sd3;
    case ($urandom_range(0, 6))
      0:       a = ANG_MIN + ANGLE_BITS'($urandom_range(0, 3));
      1:       a = ANG_MAX - ANGLE_BITS'($urandom_range(0, 3));
      2:       a = jitter;
      3:       a = ANG_PI + jitter;
      4:       a = -ANG_PI + jitter;
      5:       a = ANG_HALF_PI + jitter;
      default: a = -ANG_HALF_PI + jitter;
    endcase
    return a;
  endfunction

  function automatic logic signed [ANGLE_BITS-1:0] random_angle();
    logic [31:0] u;
    u = $urandom();
    if ($urandom_range(0, 4) == 0) return corner_angle();
    return u[ANGLE_BITS-1:0];
  endfunction

  // extremes of each field and the fold and saturation corners
  task automatic test_corner_triples();
    send_item(16'sd0, 16'sd0, 16'sd0);
    send_item(ANG_MIN, ANG_MIN, ANG_MIN);
    send_item(ANG_MAX, ANG_MAX, ANG_MAX);
    send_item(ANG_MAX, 16'sd0, 16'sd0);
    send_item(16'sd0, ANG_MAX, 16'sd0);
    send_item(16'sd0, 16'sd0, ANG_MAX);
    send_item(ANG_MIN, 16'sd0, 16'sd0);
    send_item(16'sd0, ANG_MIN, 16'sd0);
    send_item(16'sd0, 16'sd0, ANG_MIN);
    send_item(ANG_PI - 16'sd1, ANG_PI, ANG_PI + 16'sd1);
    send_item(-ANG_PI + 16'sd1, -ANG_PI, -ANG_PI - 16'sd1);
    send_item(16'sd0, ANG_HALF_PI, 16'sd0);
    send_item(16'sd0, -ANG_HALF_PI, ANG_HALF_PI);
    send_item(-16'sd1, -16'sd1, -16'sd1);
    send_item(16'sd1, 16'sd1, 16'sd1);
    send_item(ANG_MAX, ANG_MIN, ANG_MAX);
    send_item(ANG_MIN, ANG_MAX, ANG_MIN);
  endtask

  // sender holds off until every predicted result has come back
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_item(random_angle(), random_angle(), random_angle());
    in_valid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 20; i++) send_item(random_angle(), random_angle(), random_angle());
  endtask

  // back to back input against a stalling sink, fills the pipeline
  task automatic test_backpressure();
    tx_max_gap   = 0;
    rx_max_stall = 12;
    for (int i = 0; i < 80; i++) send_item(random_angle(), random_angle(), random_angle());
  endtask

  // long random stream, idling chosen per chunk
  task automatic test_random_stream();
    for (int c = 0; c < RANDOM_ITEMS / CHUNK_ITEMS; c++) begin
      tx_max_gap   = (c == 0 || $urandom_range(0, 2) != 0) ? 12 : 0;
      rx_max_stall = (c == 1 || $urandom_range(0, 2) != 0) ? 12 : 0;
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        send_item(random_angle(), random_angle(), random_angle());
      end
    end
  endtask

  // reset, run the tests in turn, drain and report
  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    roll_angle   = '0;
    pitch_angle  = '0;
    yaw_angle    = '0;
    out_ready    = 1'b0;
    fail_count   = 0;
    tx_max_gap   = 12;
    rx_max_stall = 12;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_triples();
    test_drain_pause();
    test_backpressure();
    test_random_stream();

    in_valid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_fold_cell.sv
hw/rtl/e2q_cordic_cell.sv
hw/rtl/e2q_quat_unit.sv
hw/rtl/euler_to_quaternion.sv
tb/sv/tb_top.sv
